/* rtl/core/stable_sorted_priority_queue_macros.svh */
// Assertion macros used by the queue datapath.
`ifndef STABLE_SORTED_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSPQ_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("queue assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SSPQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("queue assertion failed");

`endif

/* rtl/core/sspq_pkg.sv */
package sspq_pkg;

  localparam int unsigned CAPACITY_DEF = 16;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_REMOVED   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  typedef struct packed {
    logic               command;
    logic signed [31:0] item_value;
    logic signed [15:0] item_priority;
  } in_word_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] out_value;
    logic signed [15:0] out_priority;
    logic [4:0]         occupancy;
  } out_word_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE
  } dp_op_e;

  typedef enum logic {
    CS_IDLE,
    CS_EXEC
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_in;
    logic    load_out;
    dp_op_e  op;
    status_e code;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic remove_req;
    logic empty;
    logic full;
  } dp_stat_t;

endpackage

/* rtl/core/sspq_ctrl.sv */
module sspq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  sspq_pkg::dp_stat_t stat_i,
  output sspq_pkg::dp_cmd_t  cmd_o
);
  import sspq_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    out_valid_d      = out_valid_q;
    in_ready_o       = 1'b0;
    cmd_o.load_in    = 1'b0;
    cmd_o.load_out   = 1'b0;
    cmd_o.op         = OP_NONE;
    cmd_o.code       = ST_INSERTED;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      CS_IDLE: begin
        // A new word is taken only when the output register will be free.
        in_ready_o = !out_valid_q || out_ready_i;
        if (in_valid_i && in_ready_o) begin
          cmd_o.load_in = 1'b1;
          state_d       = CS_EXEC;
        end
      end
      CS_EXEC: begin
        cmd_o.load_out = 1'b1;
        out_valid_d    = 1'b1;
        state_d        = CS_IDLE;
        if (stat_i.remove_req) begin
          if (stat_i.empty) begin
            cmd_o.code = ST_UNDERFLOW;
          end else begin
            cmd_o.op   = OP_REMOVE;
            cmd_o.code = ST_REMOVED;
          end
        end else begin
          if (stat_i.full) begin
            cmd_o.code = ST_OVERFLOW;
          end else begin
            cmd_o.op   = OP_INSERT;
            cmd_o.code = ST_INSERTED;
          end
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/core/sspq_dpath.sv */
`include "stable_sorted_priority_queue_macros.svh"

module sspq_dpath #(
  parameter int unsigned CAPACITY = sspq_pkg::CAPACITY_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sspq_pkg::in_word_t  in_word_i,
  input  sspq_pkg::dp_cmd_t   cmd_i,
  output sspq_pkg::dp_stat_t  stat_o,
  output sspq_pkg::out_word_t out_word_o
);
  import sspq_pkg::*;

  localparam int unsigned CntW = (CAPACITY < 2) ? 1 : $clog2(CAPACITY + 1);

  in_word_t           in_q;
  out_word_t          out_q, out_d;
  logic [CntW-1:0]    count_q, count_d;
  logic signed [31:0] val_q [CAPACITY];
  logic signed [31:0] val_d [CAPACITY];
  logic signed [15:0] pri_q [CAPACITY];
  logic signed [15:0] pri_d [CAPACITY];
  logic [CAPACITY-1:0] gt;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_word_i;
    end
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Each cell compares its stored priority with the new one. The chain is
  // sorted, so the cells that are greater form one run at the back.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic prev_gt;

    assign gt[i] = (CntW'(i) < count_q) && (pri_q[i] > in_q.item_priority);

    if (i == 0) begin : g_first
      assign prev_gt = 1'b0;
    end else begin : g_rest
      assign prev_gt = gt[i-1];
    end

    always_comb begin
      val_d[i] = val_q[i];
      pri_d[i] = pri_q[i];
      case (cmd_i.op)
        OP_INSERT: begin
          if (prev_gt) begin
            if (i > 0) begin
              val_d[i] = val_q[(i > 0) ? i - 1 : 0];
              pri_d[i] = pri_q[(i > 0) ? i - 1 : 0];
            end
          end else if (gt[i] || (CntW'(i) == count_q)) begin
            val_d[i] = in_q.item_value;
            pri_d[i] = in_q.item_priority;
          end
        end
        OP_REMOVE: begin
          if (i < CAPACITY - 1) begin
            val_d[i] = val_q[(i < CAPACITY - 1) ? i + 1 : i];
            pri_d[i] = pri_q[(i < CAPACITY - 1) ? i + 1 : i];
          end
        end
        default: begin
        end
      endcase
    end

    always_ff @(posedge clk_i) begin
      val_q[i] <= val_d[i];
      pri_q[i] <= pri_d[i];
    end
  end

  always_comb begin
    count_d = count_q;
    case (cmd_i.op)
      OP_INSERT: count_d = count_q + 1'b1;
      OP_REMOVE: count_d = count_q - 1'b1;
      default:   count_d = count_q;
    endcase
  end

  always_comb begin
    out_d.status       = cmd_i.code;
    out_d.out_value    = '0;
    out_d.out_priority = '0;
    out_d.occupancy    = 5'(count_d);
    if (cmd_i.op == OP_REMOVE) begin
      out_d.out_value    = val_q[0];
      out_d.out_priority = pri_q[0];
    end
  end

  assign stat_o.remove_req = (in_q.command == CMD_REMOVE);
  assign stat_o.empty      = (count_q == '0);
  assign stat_o.full       = (count_q == CntW'(CAPACITY));
  assign out_word_o        = out_q;

  `SSPQ_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CntW'(CAPACITY))
  `SSPQ_ASSERT_NEXT(a_insert_count, clk_i, rst_ni, cmd_i.op == OP_INSERT,
                    count_q == $past(count_q) + 1'b1)
  `SSPQ_ASSERT_NEXT(a_remove_count, clk_i, rst_ni, cmd_i.op == OP_REMOVE,
                    count_q == $past(count_q) - 1'b1)
  `SSPQ_ASSERT_NEXT(a_out_zero, clk_i, rst_ni, cmd_i.load_out && cmd_i.op != OP_REMOVE,
                    out_q.out_value == '0 && out_q.out_priority == '0)

endmodule

/* rtl/core/stable_sorted_priority_queue.sv */
// A word accepted in the idle state is executed in the execute state, which
// updates the cell chain and writes the result into the output register;
// the result leaves when the consumer takes it. No new word is taken in
// the execute state; in idle, only if the output register will be free.
// Reset (rst_ni low, asynchronous) empties the queue and drops any pending
// result; the stored cell contents are not cleared.
module stable_sorted_priority_queue #(
  parameter int unsigned CAPACITY = sspq_pkg::CAPACITY_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sspq_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sspq_pkg::out_word_t out_word_o
);
  import sspq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sspq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sspq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_word_o (out_word_o)
  );

endmodule
